/* rtl/core/fbp_pkg.sv */
// fbp_pkg: shared types, constants and the coefficient ROM of the band-pass FIR.
// No dependencies; imported by fbp_mac and fir_bandpass_filter_51tap_top.
`timescale 1ns / 1ps

package fbp_pkg;

	// default configuration of the top level
	localparam int DEF_TAPS         = 51;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COEFF_SHIFT  = 8;

	// coefficient ROM geometry
	localparam int ROM_LEN   = 51;
	localparam int ROM_IDX_W = 6;
	localparam int COEF_W    = 11;
	localparam int TAP_IDX_W = 8;

	localparam logic signed [COEF_W-1:0] COEF_ROM [ROM_LEN] = '{
		-11'sd7,   11'sd0,  -11'sd10,  -11'sd7,   -11'sd1,  -11'sd20,
		-11'sd3,  -11'sd13, -11'sd25,   11'sd0,  -11'sd36,  -11'sd16,
		-11'sd15, -11'sd52,  11'sd1,   -11'sd53, -11'sd37,  -11'sd4,
		-11'sd93,  11'sd15, -11'sd66,  -11'sd80,  11'sd74,  -11'sd244,
		 11'sd214, 11'sd954, 11'sd214, -11'sd244, 11'sd74,  -11'sd80,
		-11'sd66,  11'sd15, -11'sd93,  -11'sd4,  -11'sd37,  -11'sd53,
		 11'sd1,  -11'sd52, -11'sd15,  -11'sd16, -11'sd36,   11'sd0,
		-11'sd25, -11'sd13, -11'sd3,   -11'sd20, -11'sd1,   -11'sd7,
		-11'sd10,  11'sd0,  -11'sd7
	};

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} seq_state_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

	// coefficient of tap k; taps past the ROM have coefficient zero
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] k);
		logic signed [COEF_W-1:0] c;
		if (int'(k) < ROM_LEN) begin
			c = COEF_ROM[k[ROM_IDX_W-1:0]];
		end else begin
			c = '0;
		end
		return c;
	endfunction

endpackage

/* rtl/core/fbp_mac.sv */
// fbp_mac: shared multiply-accumulate unit of the FIR; one tap per cycle.
// Product register, truncate-toward-zero scaling, wrapping accumulator.
// Depends on fbp_pkg.
`timescale 1ns / 1ps

module fbp_mac
	import fbp_pkg::*;
#(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COEFF_SHIFT  = DEF_COEFF_SHIFT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mac_ctl_t                       ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [COEF_W-1:0]       coef,
	output logic [SAMPLE_WIDTH-1:0]        acc
);

	localparam int PW = SAMPLE_WIDTH + COEF_W;
	localparam logic signed [PW:0] BIAS = (PW+1)'((64'd1 << COEFF_SHIFT) - 64'd1);

	logic signed [PW-1:0]   prod_s2;
	logic                   vld_s2;
	logic signed [PW:0]     biased;
	logic signed [PW:0]     scaled;
	logic [SAMPLE_WIDTH-1:0] acc_q;

	// product register
	always_ff @(posedge clk) begin
		prod_s2 <= sample * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.valid && !ctl.clear;
		end
	end

	// divide by 2^COEFF_SHIFT, rounding toward zero for negative products
	always_comb begin
		biased = {prod_s2[PW-1], prod_s2} + (prod_s2[PW-1] ? BIAS : '0);
		scaled = biased >>> COEFF_SHIFT;
	end

	// accumulator keeps only the low bits, so the sum wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + scaled[SAMPLE_WIDTH-1:0];
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/core/fir_bandpass_filter_51tap_top.sv */
// fir_bandpass_filter_51tap_top: 51-tap band-pass FIR, one shared MAC walks the taps.
// Depends on fbp_pkg and fbp_mac.
//
// Usage:
//   Input stream s_*: one signed sample per beat in s_tdata. Output stream m_*:
//   one filtered sample per input beat in m_tdata, in order.
//   Each sample is written to a circular delay line (a TAPS-entry memory), then
//   the sequencer reads one tap per cycle, newest sample first, and feeds the
//   shared multiply-accumulate unit (read register, product register, accumulator).
//   Each sample passes through the states in order: accept (ST_IDLE), the tap
//   reads (ST_RUN), draining the MAC pipeline (ST_DRAIN) and loading the output
//   register (ST_FINISH). s_tready is high only between samples.
//   Reset: the delay line reads as all zero through per-entry valid bits cleared
//   at reset; the write pointer returns to slot zero. No clearing pass is needed.
//   Stall: the result sits in an output register until m_tready; a finished
//   sample waits in the sequencer if the previous result has not been taken,
//   and the next input beat is taken only once it has moved to the output.
`timescale 1ns / 1ps

module fir_bandpass_filter_51tap_top
	import fbp_pkg::*;
#(
	parameter int TAPS         = DEF_TAPS,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	parameter int COEFF_SHIFT  = DEF_COEFF_SHIFT,
	localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in, rest zero
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata    // [SAMPLE_WIDTH-1:0] sample_out, rest zero
);

	localparam int PTR_W = $clog2(TAPS);

	seq_state_t              state_q, state_d;
	logic [PTR_W-1:0]        wp_q;
	logic [PTR_W-1:0]        rd_idx_q;
	logic [PTR_W-1:0]        tap_q;
	logic                    drain_q;
	logic [TAPS-1:0]         valid_q;
	logic [SAMPLE_WIDTH-1:0] mem [TAPS];

	logic                    accept;
	logic                    issue;
	logic                    out_load;

	logic [SAMPLE_WIDTH-1:0] rd_s1;
	logic                    rdv_s1;
	logic                    vld_s1;
	logic signed [COEF_W-1:0] coef_s1;
	logic signed [SAMPLE_WIDTH-1:0] mac_sample;
	mac_ctl_t                mac_ctl;
	logic [SAMPLE_WIDTH-1:0] acc;

	logic                    m_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer strobes
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (tap_q == PTR_W'(TAPS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// pointers, tap counter, drain counter, entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rd_idx_q <= '0;
			tap_q    <= '0;
			drain_q  <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (accept) begin
				valid_q[wp_q] <= 1'b1;
				wp_q          <= (wp_q == PTR_W'(TAPS - 1)) ? '0 : wp_q + 1'b1;
				rd_idx_q      <= wp_q;
				tap_q         <= '0;
			end
			if (issue) begin
				tap_q    <= tap_q + 1'b1;
				rd_idx_q <= (rd_idx_q == '0) ? PTR_W'(TAPS - 1) : rd_idx_q - 1'b1;
			end
			drain_q <= (state_q == ST_DRAIN) ? !drain_q : 1'b0;
		end
	end

	// delay line memory, registered read
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wp_q] <= s_tdata[SAMPLE_WIDTH-1:0];
		end
		rd_s1   <= mem[rd_idx_q];
		rdv_s1  <= valid_q[rd_idx_q];
		coef_s1 <= coef_at(TAP_IDX_W'(tap_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	// never-written entries read as zero
	assign mac_sample    = rdv_s1 ? signed'(rd_s1) : '0;
	assign mac_ctl.clear = accept;
	assign mac_ctl.valid = vld_s1;

	fbp_mac #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_SHIFT (COEFF_SHIFT)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.sample(mac_sample),
		.coef  (coef_s1),
		.acc   (acc)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= acc;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'(out_q);

	// checks
	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (tap_q == '0))
		else $error("accepted beat did not start the tap walk at tap zero");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_tready))
		else $error("output register overwritten while holding an untaken beat");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (int'(rd_idx_q) < TAPS) && (int'(tap_q) < TAPS))
		else $error("tap read index out of range");

endmodule
